@@ hw/rtl/dfps_pkg.sv @@
// Shared types and constants for the disk-fill pixel store.
// Used by the controller, datapath, top level and checker; no dependencies.
package dfps_pkg;

    // Operation codes carried in the low bits of the input word
    typedef enum logic [1:0] {
        OP_WRITE       = 2'd0,
        OP_FILL        = 2'd1,
        OP_READ        = 2'd2,
        OP_CLEAR_DIRTY = 2'd3
    } op_t;

    // Input word layout (lowest bit first)
    localparam int OP_LSB     = 0;
    localparam int OP_W       = 2;
    localparam int COORD_W    = 12;
    localparam int CX_LSB     = OP_LSB + OP_W;
    localparam int CY_LSB     = CX_LSB + COORD_W;
    localparam int RAD_W      = 8;
    localparam int RAD_LSB    = CY_LSB + COORD_W;
    localparam int PIX_W      = 32;
    localparam int COLOUR_LSB = RAD_LSB + RAD_W;
    localparam int IN_BITS    = COLOUR_LSB + PIX_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Output word layout (lowest bit first)
    localparam int COUNT_W     = 13;
    localparam int RD_LSB      = 0;
    localparam int COUNT_LSB   = RD_LSB + PIX_W;
    localparam int DIRTY_LSB   = COUNT_LSB + COUNT_W;
    localparam int OUT_BITS    = DIRTY_LSB + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Scan offset width: covers -127 .. 126
    localparam int OFS_W = 9;
    // Magnitude of an offset: at most 127
    localparam int MAG_W = 7;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;    // write one all-ones entry of the reset sweep
        logic load;          // capture the input word
        logic start;         // set scan offsets, clear count and read data
        logic eval;          // test the current point and queue its write
        logic disk_test;     // apply the disk test and advance the scan
        logic read_issue;    // present the point address to the read port
        logic read_capture;  // take the registered read data
        logic clear_dirty;   // drop the dirty flag
        logic result_load;   // move the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;    // sweep is at the last entry
        op_t  op;            // operation of the held word
        logic box_empty;     // half extent is zero
        logic scan_last;     // scan is at the last point of the box
    } status_t;

endpackage

@@ hw/rtl/dfps_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dfps_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/dfps_ctrl.sv @@
// Controller state machine for the disk-fill pixel store.
// Depends on dfps_pkg; drives the datapath through dfps_pkg::cmd_t.
module dfps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  dfps_pkg::status_t status,
    output dfps_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_DISPATCH  = 8'b0000_0100,
        S_WRITE     = 8'b0000_1000,
        S_SCAN      = 8'b0001_0000,
        S_READ      = 8'b0010_0000,
        S_READ_WAIT = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.start = 1'b1;
                unique case (status.op)
                    dfps_pkg::OP_WRITE: state_next = S_WRITE;
                    dfps_pkg::OP_FILL: begin
                        state_next = status.box_empty ? S_FINISH : S_SCAN;
                    end
                    dfps_pkg::OP_READ: state_next = S_READ;
                    dfps_pkg::OP_CLEAR_DIRTY: begin
                        cmd.clear_dirty = 1'b1;
                        state_next      = S_FINISH;
                    end
                endcase
            end
            S_WRITE: begin
                cmd.eval   = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN: begin
                cmd.eval      = 1'b1;
                cmd.disk_test = 1'b1;
                if (status.scan_last) begin
                    state_next = S_FINISH;
                end
            end
            S_READ: begin
                cmd.read_issue = 1'b1;
                state_next     = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                cmd.read_capture = 1'b1;
                state_next       = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (cmd.result_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ hw/rtl/dfps_datapath.sv @@
// Datapath for the disk-fill pixel store: held word, scan offsets, disk test,
// address generation, pixel memory, counters and result register.
// Depends on dfps_pkg and dfps_ram.
module dfps_datapath #(
    parameter int STORE_WIDTH  = 64,
    parameter int STORE_HEIGHT = 64,
    parameter int DEPTH        = 4096,
    parameter int ADDR_W       = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dfps_pkg::cmd_t                      cmd,
    output dfps_pkg::status_t                   status,
    input  logic [dfps_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic [dfps_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int PW = dfps_pkg::PIX_W;
    localparam int CW = dfps_pkg::COORD_W;
    localparam int NW = dfps_pkg::COUNT_W;
    localparam int OW = dfps_pkg::OFS_W;
    localparam int MW = dfps_pkg::MAG_W;
    localparam int RW = dfps_pkg::RAD_W;
    // Point coordinate: coord plus sign-extended offset, with a sign bit
    localparam int PTW = CW + 2;

    // Held input word
    dfps_pkg::op_t   op_reg;
    logic [CW-1:0]   cx_reg, cy_reg;
    logic [RW-1:0]   rad_reg;
    logic [PW-1:0]   colour_reg;

    // Scan and result state
    logic signed [OW-1:0] dx_reg, dy_reg;
    logic [NW-1:0]        count_reg;
    logic                 dirty_reg;
    logic [PW-1:0]        rd_reg;
    logic [dfps_pkg::OUT_BITS-1:0] result_reg;
    logic                 wr_valid_reg;
    logic [ADDR_W-1:0]    wr_addr_reg;
    logic [ADDR_W-1:0]    clear_addr_reg;

    logic [MW-1:0]        half;
    logic signed [OW-1:0] half_s, neg_half, half_m1;
    logic [PTW-1:0]       px, py;
    logic                 in_store;
    logic [MW-1:0]        dx_mag, dy_mag;
    logic [2*MW-1:0]      dx_sq, dy_sq;
    logic [2*MW:0]        dist_sum;
    logic [2*RW-1:0]      rad_sq;
    logic                 in_disk, hit;
    logic [ADDR_W-1:0]    point_addr;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [PW-1:0]        ram_wdata;
    logic [PW-1:0]        ram_q;

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= dfps_pkg::op_t'(s_tdata[dfps_pkg::OP_LSB +: dfps_pkg::OP_W]);
            cx_reg     <= s_tdata[dfps_pkg::CX_LSB +: CW];
            cy_reg     <= s_tdata[dfps_pkg::CY_LSB +: CW];
            rad_reg    <= s_tdata[dfps_pkg::RAD_LSB +: RW];
            colour_reg <= s_tdata[dfps_pkg::COLOUR_LSB +: PW];
        end
    end

    // Box bounds from the half extent
    assign half     = rad_reg[RW-1:1];
    assign half_s   = signed'({2'b00, half});
    assign neg_half = -half_s;
    assign half_m1  = half_s - OW'(1);

    // Step the scan offsets, rows inside columns
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            if (op_reg == dfps_pkg::OP_FILL) begin
                dx_reg <= neg_half;
                dy_reg <= neg_half;
            end else begin
                dx_reg <= '0;
                dy_reg <= '0;
            end
        end else if (cmd.eval && cmd.disk_test) begin
            if (dy_reg == half_m1) begin
                dy_reg <= neg_half;
                dx_reg <= dx_reg + OW'(1);
            end else begin
                dy_reg <= dy_reg + OW'(1);
            end
        end
    end

    // Point position and bounds check
    assign px = {2'b00, cx_reg} + {{(PTW-OW){dx_reg[OW-1]}}, dx_reg};
    assign py = {2'b00, cy_reg} + {{(PTW-OW){dy_reg[OW-1]}}, dy_reg};
    assign in_store = !px[PTW-1] && (px < PTW'(STORE_WIDTH)) &&
                      !py[PTW-1] && (py < PTW'(STORE_HEIGHT));

    // Disk test: 4*(dx^2 + dy^2) < radius^2
    assign dx_mag   = dx_reg[OW-1] ? MW'(-dx_reg) : MW'(dx_reg);
    assign dy_mag   = dy_reg[OW-1] ? MW'(-dy_reg) : MW'(dy_reg);
    assign dx_sq    = {{MW{1'b0}}, dx_mag} * {{MW{1'b0}}, dx_mag};
    assign dy_sq    = {{MW{1'b0}}, dy_mag} * {{MW{1'b0}}, dy_mag};
    assign dist_sum = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign rad_sq   = {{RW{1'b0}}, rad_reg} * {{RW{1'b0}}, rad_reg};
    assign in_disk  = {dist_sum, 2'b00} < {1'b0, rad_sq};
    assign hit      = in_store && (!cmd.disk_test || in_disk);

    // Row-major address of the point
    assign point_addr = ADDR_W'(py[PTW-2:0]) * ADDR_W'(STORE_WIDTH) + ADDR_W'(px[PTW-2:0]);

    // Queue the pixel write for the cycle after the test
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= cmd.eval && hit;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= point_addr;
    end

    // Count written pixels, saturating
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            count_reg <= '0;
        end else if (cmd.eval && hit && (count_reg != dfps_pkg::COUNT_MAX)) begin
            count_reg <= count_reg + NW'(1);
        end
    end

    // Dirty flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg <= 1'b0;
        end else if (cmd.clear_dirty) begin
            dirty_reg <= 1'b0;
        end else if (cmd.eval && hit) begin
            dirty_reg <= 1'b1;
        end
    end

    // Read data, zero when the point is off the store
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rd_reg <= '0;
        end else if (cmd.read_capture) begin
            rd_reg <= in_store ? ram_q : '0;
        end
    end

    // Reset sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_addr_reg <= '0;
        end else if (cmd.clear_step) begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            result_reg <= {dirty_reg, count_reg, rd_reg};
        end
    end

    assign m_tdata = {{(dfps_pkg::OUT_TDATA_W - dfps_pkg::OUT_BITS){1'b0}}, result_reg};

    // Memory write mux: sweep or queued pixel write
    assign ram_we    = cmd.clear_step || wr_valid_reg;
    assign ram_waddr = cmd.clear_step ? clear_addr_reg : wr_addr_reg;
    assign ram_wdata = cmd.clear_step ? {PW{1'b1}} : colour_reg;

    dfps_ram #(
        .WIDTH  (PW),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read_issue),
        .raddr (point_addr),
        .rdata (ram_q)
    );

    // Status to the controller
    assign status.clear_last = (clear_addr_reg == ADDR_W'(DEPTH - 1));
    assign status.op         = op_reg;
    assign status.box_empty  = (half == '0);
    assign status.scan_last  = (dx_reg == half_m1) && (dy_reg == half_m1);

endmodule

@@ hw/rtl/disk_fill_pixel_store_unit.sv @@
// Top level of the disk-fill pixel store: controller plus datapath.
// Depends on dfps_pkg, dfps_ctrl, dfps_datapath and dfps_ram.
//
// Usage:
//   s_ channel takes one word per operation: write pixel, fill disk, read
//   pixel or clear the dirty flag. m_ channel returns one word per input
//   word: read colour, pixels written and the dirty flag after the operation.
//   Words are handled one at a time; s_tready is high only while idle.
//   Each word passes through the idle, dispatch and finish states, plus the
//   write state for a write, the read and read-wait states for a read, none
//   for a clear-dirty, and for a fill one scan state per point of its
//   (2*h)^2 box with h = disk_radius/2 (none if h is zero), so up to 254*254
//   points. The fill scans its box one point per cycle through a single
//   disk-test and memory write path.
//   The result sits in an output register, so the next word is accepted
//   while it waits; if the receiver stalls, the following result holds in
//   the finish state until the output register frees up.
//   Reset: aresetn is synchronous, active low. After reset the block sweeps
//   the pixel memory to all ones, one entry per cycle, over all
//   STORE_WIDTH*STORE_HEIGHT entries (4096 by default); s_tready stays low.
module disk_fill_pixel_store_unit #(
    parameter int STORE_WIDTH  = 64,
    parameter int STORE_HEIGHT = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // operation[1:0], coord_x[13:2], coord_y[25:14], disk_radius[33:26],
    // colour[65:34], zero fill above
    input  logic [dfps_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_colour[31:0], pixels_written[44:32], dirty[45], zero fill above
    output logic [dfps_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int DEPTH  = STORE_WIDTH * STORE_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dfps_pkg::cmd_t    cmd;
    dfps_pkg::status_t status;

    dfps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dfps_datapath #(
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_HEIGHT (STORE_HEIGHT),
        .DEPTH        (DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

@@ hw/rtl/dfps_checker.sv @@
// Port-level checker for the disk-fill pixel store, bound to the top level.
// Depends on dfps_pkg.
module dfps_port_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [dfps_pkg::IN_TDATA_W-1:0]     s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [dfps_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int NL = dfps_pkg::COUNT_LSB;
    localparam int NH = dfps_pkg::COUNT_LSB + dfps_pkg::COUNT_W - 1;
    localparam int RH = dfps_pkg::RD_LSB + dfps_pkg::PIX_W - 1;
    localparam int DB = dfps_pkg::DIRTY_LSB;

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // One word in flight: input side closes right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Any written pixel leaves the store dirty
    a_written_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[NH:NL] != '0) |-> m_tdata[DB])
        else $error("pixels written but dirty flag low");

    // Only a read returns colour, and a read writes nothing
    a_read_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[RH:dfps_pkg::RD_LSB] != '0) |-> (m_tdata[NH:NL] == '0))
        else $error("read result also reports written pixels");

endmodule

bind disk_fill_pixel_store_unit dfps_port_checker u_dfps_port_checker (.*);

@@ sim/dfps_checker.sv @@
// Checker for the disk-fill pixel store: watches both stream channels, keeps its own
// copy of the pixel store and dirty flag, and compares every result word with its prediction.
// Depends on dfps_pkg for the operation codes and the word layouts.
module dfps_checker #(
    parameter int STORE_WIDTH  = 64,
    parameter int STORE_HEIGHT = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // operation, coord_x, coord_y, disk_radius, colour, zero fill above
    input  logic [dfps_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // read_colour, pixels_written, dirty, zero fill above
    input  logic [dfps_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output int                                  fail_count,
    output int                                  results_due_count,
    output int                                  results_checked,
    output int                                  pixels_painted
);
    timeunit 1ns;
    timeprecision 1ps;

    import dfps_pkg::*;

    localparam int PIXELS = STORE_WIDTH * STORE_HEIGHT;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [PIX_W-1:0]   read_colour;
        logic [COUNT_W-1:0] pixels_written;
        logic               dirty;
    } pixel_result_t;

    logic [PIX_W-1:0] pixel_copy [PIXELS];
    logic             dirty_copy;
    pixel_result_t    results_due [$];

    function automatic bit on_store(input int col, input int row);
        return col >= 0 && row >= 0 && col < STORE_WIDTH && row < STORE_HEIGHT;
    endfunction

    // Count the failure and print one line about it, for the first MAX_PRINTED failures only
    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("[%0t] MISMATCH on result %0d, %s: got 0x%08h, want 0x%08h",
                     $realtime, results_checked, what, seen, wanted);
        end
    endtask

    // Apply one word to the local store copy and work out the result it produces
    task automatic predict_word(input op_t op, input int cx, input int cy, input int radius,
                                input logic [PIX_W-1:0] colour, output pixel_result_t res);
        int half;
        int limit;
        int col;
        int row;
        int dx;
        int dy;
        int count;
        count = 0;
        res = '0;
        case (op)
            OP_WRITE: begin
                if (on_store(cx, cy)) begin
                    pixel_copy[cy * STORE_WIDTH + cx] = colour;
                    count = 1;
                end
            end
            OP_FILL: begin
                // Scan the half-open box around the centre; keep points strictly inside
                half = radius / 2;
                limit = radius * radius;
                for (col = cx - half; col < cx + half; col++) begin
                    for (row = cy - half; row < cy + half; row++) begin
                        dx = col - cx;
                        dy = row - cy;
                        if (4 * (dx * dx + dy * dy) < limit && on_store(col, row)) begin
                            pixel_copy[row * STORE_WIDTH + col] = colour;
                            count++;
                        end
                    end
                end
            end
            OP_READ: begin
                if (on_store(cx, cy)) begin
                    res.read_colour = pixel_copy[cy * STORE_WIDTH + cx];
                end
            end
            OP_CLEAR_DIRTY: begin
                dirty_copy = 1'b0;
            end
            default: ;
        endcase
        if (count > 0) begin
            dirty_copy = 1'b1;
        end
        pixels_painted += count;
        // Saturate the count at the width of the field
        res.pixels_written = (count > int'(COUNT_MAX)) ? COUNT_MAX : count[COUNT_W-1:0];
        res.dirty = dirty_copy;
    endtask

    // Compare results first, then predict the word accepted at this edge
    always @(posedge aclk) begin : watch
        pixel_result_t seen;
        pixel_result_t wanted;
        if (!aresetn) begin
            for (int k = 0; k < PIXELS; k++) begin
                pixel_copy[k] = '1;
            end
            dirty_copy = 1'b0;
            results_due.delete();
            fail_count = 0;
            results_checked = 0;
            pixels_painted = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.read_colour = m_tdata[RD_LSB +: PIX_W];
                seen.pixels_written = m_tdata[COUNT_LSB +: COUNT_W];
                seen.dirty = m_tdata[DIRTY_LSB];
                if (results_due.size() == 0) begin
                    report_mismatch("word with nothing expected", seen.read_colour, '0);
                end else begin
                    wanted = results_due.pop_front();
                    if (seen.read_colour !== wanted.read_colour) begin
                        report_mismatch("read_colour", seen.read_colour, wanted.read_colour);
                    end
                    if (seen.pixels_written !== wanted.pixels_written) begin
                        report_mismatch("pixels_written", 32'(seen.pixels_written),
                                        32'(wanted.pixels_written));
                    end
                    if (seen.dirty !== wanted.dirty) begin
                        report_mismatch("dirty", 32'(seen.dirty), 32'(wanted.dirty));
                    end
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_word(op_t'(s_tdata[OP_LSB +: OP_W]),
                             int'(s_tdata[CX_LSB +: COORD_W]),
                             int'(s_tdata[CY_LSB +: COORD_W]),
                             int'(s_tdata[RAD_LSB +: RAD_W]),
                             s_tdata[COLOUR_LSB +: PIX_W], wanted);
                results_due.push_back(wanted);
            end
        end
        results_due_count = results_due.size();
    end

endmodule

@@ sim/tb_top.sv @@
// Top of the disk-fill pixel store testbench: clock, reset, stimulus and verdict.
// Depends on dfps_pkg, disk_fill_pixel_store_unit and dfps_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfps_pkg::*;

    localparam int STORE_W         = 64;
    localparam int STORE_H         = 64;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 100;
    localparam int LARGE_FILL_CAP  = 3;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int results_due_count;
    int results_checked;
    int pixels_painted;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_asks = 0;
    int hold_done = 0;
    int large_fills_left = LARGE_FILL_CAP;
    int words_by_op [4] = '{0, 0, 0, 0};

    disk_fill_pixel_store_unit #(
        .STORE_WIDTH  (STORE_W),
        .STORE_HEIGHT (STORE_H)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dfps_checker #(
        .STORE_WIDTH  (STORE_W),
        .STORE_HEIGHT (STORE_H)
    ) pixel_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .fail_count        (fail_count),
        .results_due_count (results_due_count),
        .results_checked   (results_checked),
        .pixels_painted    (pixels_painted)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit, well beyond the slowest correct run
    initial begin
        #50_000_000;
        $display("Timeout: %0d results still due", results_due_count);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_done) begin
                repeat (HOLD_OFF_CYCLES) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
                hold_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one word after an optional random gap, hold it until accepted
    task automatic send_word(input op_t op, input int x, input int y, input int radius,
                             input logic [PIX_W-1:0] colour);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, colour, radius[RAD_W-1:0],
                    y[COORD_W-1:0], x[COORD_W-1:0], op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_by_op[int'(op)]++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (results_due_count == 0);
    endtask

    // Mostly small disks near the store, now and then far-off points and big disks
    task automatic send_random_word();
        int pick;
        int x;
        int y;
        int radius;
        op_t op;
        pick = $urandom_range(99);
        if (pick < 25) op = OP_WRITE;
        else if (pick < 55) op = OP_FILL;
        else if (pick < 90) op = OP_READ;
        else op = OP_CLEAR_DIRTY;
        if ($urandom_range(99) < 85) begin
            x = $urandom_range(STORE_W + 7);
            y = $urandom_range(STORE_H + 7);
        end else begin
            x = $urandom_range(4095);
            y = $urandom_range(4095);
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
            radius = $urandom_range(20);
        end else if (pick < 97 || large_fills_left == 0) begin
            radius = $urandom_range(64, 21);
        end else begin
            radius = $urandom_range(255, 65);
            if (op == OP_FILL) large_fills_left--;
        end
        send_word(op, x, y, radius, $urandom());
    endtask

    // Stimulus and verdict
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 14;
        recv_idle_pct = 62;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: store edges, out-of-store points, empty and clipped disks
        send_word(OP_READ, 0, 0, 0, 32'h0);
        send_word(OP_WRITE, 0, 0, 0, 32'h0000_0000);
        send_word(OP_WRITE, STORE_W - 1, STORE_H - 1, 255, 32'hFFFF_FFFF);
        send_word(OP_WRITE, STORE_W, 0, 0, 32'hDEAD_BEEF);
        send_word(OP_WRITE, 0, STORE_H, 0, 32'hDEAD_BEEF);
        send_word(OP_READ, 0, 0, 0, 32'h0);
        send_word(OP_READ, STORE_W - 1, STORE_H - 1, 0, 32'h0);
        send_word(OP_READ, 4095, 4095, 0, 32'hFFFF_FFFF);
        send_word(OP_CLEAR_DIRTY, 0, 0, 0, 32'h0);
        send_word(OP_WRITE, 4095, 17, 0, 32'h1234_5678);
        send_word(OP_FILL, 20, 20, 0, 32'h0101_0101);
        send_word(OP_FILL, 20, 20, 1, 32'h0202_0202);
        send_word(OP_FILL, 10, 10, 2, 32'h0303_0303);
        send_word(OP_FILL, 30, 5, 3, 32'h0404_0404);
        send_word(OP_FILL, 0, 0, 9, 32'h0505_0505);
        send_word(OP_FILL, STORE_W - 1, STORE_H - 1, 10, 32'h0606_0606);
        send_word(OP_READ, 0, 0, 0, 32'h0);
        send_word(OP_FILL, 4095, 4095, 255, 32'h0707_0707);
        send_word(OP_FILL, STORE_W / 2, STORE_H / 2, 255, 32'hA5A5_5A5A);
        send_word(OP_READ, 17, 42, 0, 32'h0);
        send_word(OP_CLEAR_DIRTY, 0, 0, 0, 32'h0);
        send_word(OP_READ, 0, STORE_H - 1, 0, 32'h0);
        send_word(OP_WRITE, 5, 5, 128, 32'h8000_0001);

        // Random, sender mostly busy and receiver mostly stalled
        repeat (40) send_random_word();
        drain_results();

        // Random, the other way round
        send_idle_pct = 62;
        recv_idle_pct = 14;
        repeat (40) send_random_word();
        drain_results();

        // Random at full rate, opening with a long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks++;
        repeat (40) send_random_word();

        // Let the last results out, then watch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d writes, %0d disk fills, %0d reads, %0d dirty clears",
                 words_by_op[int'(OP_WRITE)], words_by_op[int'(OP_FILL)],
                 words_by_op[int'(OP_READ)], words_by_op[int'(OP_CLEAR_DIRTY)]);
        $display("Checked %0d result words, %0d pixels painted, %0d mismatches",
                 results_checked, pixels_painted, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
